// ===== rtl/ievq_pkg.sv =====
// Shared types and constants for the input event queue with knob filter.
// Holds payload structs, command codes and controller/datapath handshake structs.
// No dependencies.
`default_nettype none

package ievq_pkg;

  // Queue geometry
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned KEY_W    = 3;
  localparam int unsigned MX_W     = 2;
  localparam int unsigned RAW_W    = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned TYPE_W   = 4;
  localparam int unsigned PARAM_W  = 7;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Knob level mapping
  localparam int unsigned LEVEL_COUNT = 101;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(LEVEL_COUNT - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(50);
  localparam int unsigned DIVIDEND_W  = RAW_W + LEVEL_W;

  // Key handling
  localparam logic [KEY_W-1:0] KEY_COUNT = KEY_W'(4);

  // Event type codes
  localparam logic [TYPE_W-1:0] TYPE_SHORT_BASE = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] TYPE_LONG_BASE  = TYPE_W'(4);
  localparam logic [TYPE_W-1:0] TYPE_MATRIX     = TYPE_W'(8);
  localparam logic [TYPE_W-1:0] TYPE_KNOB       = TYPE_W'(9);

  // Configuration reset values
  localparam logic [RAW_W-1:0] FULL_SCALE_RESET = RAW_W'(2740);
  localparam logic [RAW_W-1:0] MOVE_STEP_RESET  = RAW_W'(60);
  localparam logic [GAP_W-1:0] MIN_GAP_RESET    = GAP_W'(200);

  typedef enum logic [CMD_W-1:0] {
    CMD_SHORT  = 3'd0,
    CMD_LONG   = 3'd1,
    CMD_MATRIX = 3'd2,
    CMD_KNOB   = 3'd3,
    CMD_POP    = 3'd4,
    CMD_FLUSH  = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE = 2'd0,
    CFG_MOVE_STEP  = 2'd1,
    CFG_MIN_GAP    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  key_index;
    logic [MX_W-1:0]   matrix_row;
    logic [MX_W-1:0]   matrix_col;
    logic [RAW_W-1:0]  pot_raw;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic               event_valid;
    logic [TYPE_W-1:0]  event_type;
    logic [PARAM_W-1:0] event_param;
    logic [LEVEL_W-1:0] knob_level;
    logic [FILL_W-1:0]  queue_fill;
    logic               oldest_dropped;
  } out_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  etype;
    logic [PARAM_W-1:0] param;
  } event_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic div_start;
    logic exec;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic new_is_knob;
    logic div_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ievq_div.sv =====
// Bit-serial restoring divider for the knob level mapping.
// One quotient bit per cycle; depends on ievq_pkg.
`default_nettype none

module ievq_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [ievq_pkg::DIVIDEND_W-1:0] dividend_i,
  input  wire logic [ievq_pkg::RAW_W-1:0]      divisor_i,
  output logic                                 done_o,
  output logic [ievq_pkg::DIVIDEND_W-1:0]      quotient_o
);
  import ievq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [RAW_W-1:0]      rem_q, rem_d;
  logic [RAW_W-1:0]      dvs_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [RAW_W:0]        shifted, trial;
  logic                  fits;

  // One restoring step
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? trial[RAW_W-1:0] : shifted[RAW_W-1:0];
    quo_d   = {quo_q[DIVIDEND_W-2:0], fits};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Last step completes at this edge
  assign done_o     = busy_q && (cnt_q == CNT_LAST);
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/ievq_datapath.sv =====
// Datapath: config registers, event queue, knob filter state and output register.
// Depends on ievq_pkg and ievq_div.
`default_nettype none

module ievq_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ievq_pkg::in_item_t              in_data_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [ievq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ievq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            out_stall_i,
  output logic                                 out_valid_o,
  output ievq_pkg::out_item_t                  out_data_o,
  input  wire ievq_pkg::ctrl_cmd_t             cmd_i,
  output ievq_pkg::ctrl_stat_t                 stat_o
);
  import ievq_pkg::*;

  // Configuration
  logic [RAW_W-1:0] full_scale_q, move_step_q;
  logic [GAP_W-1:0] min_gap_q;

  // Queue
  event_t            store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  rd_q, rd_d, wr_q, wr_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  // Knob state
  logic [RAW_W-1:0]   ref_q, ref_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               seeded_q, seeded_d;
  logic [TIME_W-1:0]  last_q, last_d;

  // Item and filter checks
  in_item_t          in_q;
  logic              gap_ok_q, move_ok_q;
  logic [TIME_W-1:0] elapsed;
  logic [RAW_W-1:0]  raw_diff;

  // Divider
  logic [RAW_W-1:0]      fs_eff;
  logic [DIVIDEND_W-1:0] product, quotient;
  logic                  div_done;
  logic [LEVEL_W-1:0]    new_level;

  // Result
  out_item_t         out_q, out_d;
  logic              out_valid_q;
  logic              push;
  event_t            push_ev;
  logic              ev_valid, dropped;
  event_t            pop_ev;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RESET;
      move_step_q  <= MOVE_STEP_RESET;
      min_gap_q    <= MIN_GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FULL_SCALE: full_scale_q <= cfg_wdata_i[RAW_W-1:0];
        CFG_MOVE_STEP:  move_step_q  <= cfg_wdata_i[RAW_W-1:0];
        CFG_MIN_GAP:    min_gap_q    <= cfg_wdata_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  // Gap and movement checks, settled long before a knob item executes
  assign elapsed  = in_q.now_ms - last_q;
  assign raw_diff = (in_q.pot_raw >= ref_q) ? (in_q.pot_raw - ref_q) : (ref_q - in_q.pot_raw);

  always_ff @(posedge clk_i) begin
    gap_ok_q  <= elapsed >= TIME_W'(min_gap_q);
    move_ok_q <= raw_diff >= move_step_q;
  end

  // Level mapping: raw * LEVEL_COUNT / full_scale
  assign fs_eff  = (full_scale_q == '0) ? RAW_W'(1) : full_scale_q;
  assign product = DIVIDEND_W'(in_q.pot_raw) * DIVIDEND_W'(LEVEL_COUNT);

  ievq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (product),
    .divisor_i  (fs_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign new_level = (quotient >= DIVIDEND_W'(LEVEL_COUNT)) ? LEVEL_MAX
                                                            : quotient[LEVEL_W-1:0];

  assign pop_ev = store_q[rd_q];

  // Command execution
  always_comb begin
    rd_d     = rd_q;
    wr_d     = wr_q;
    fill_d   = fill_q;
    ref_d    = ref_q;
    level_d  = level_q;
    seeded_d = seeded_q;
    last_d   = last_q;
    push     = 1'b0;
    push_ev  = '0;
    ev_valid = 1'b0;
    dropped  = 1'b0;

    unique case (cmd_e'(in_q.command))
      CMD_SHORT: begin
        if (in_q.key_index < KEY_COUNT) begin
          push          = 1'b1;
          push_ev.etype = TYPE_SHORT_BASE + TYPE_W'(in_q.key_index);
        end
      end
      CMD_LONG: begin
        if (in_q.key_index < KEY_COUNT) begin
          push          = 1'b1;
          push_ev.etype = TYPE_LONG_BASE + TYPE_W'(in_q.key_index);
        end
      end
      CMD_MATRIX: begin
        push          = 1'b1;
        push_ev.etype = TYPE_MATRIX;
        push_ev.param = PARAM_W'({in_q.matrix_row, in_q.matrix_col});
      end
      CMD_KNOB: begin
        if (!seeded_q) begin
          seeded_d = 1'b1;
          ref_d    = in_q.pot_raw;
          level_d  = new_level;
        end else if (gap_ok_q && move_ok_q) begin
          ref_d = in_q.pot_raw;
          if (new_level != level_q) begin
            level_d       = new_level;
            last_d        = in_q.now_ms;
            push          = 1'b1;
            push_ev.etype = TYPE_KNOB;
            push_ev.param = PARAM_W'(new_level);
          end
        end
      end
      CMD_POP: begin
        if (fill_q != '0) begin
          ev_valid = 1'b1;
          rd_d     = ptr_next(rd_q);
          fill_d   = fill_q - 1'b1;
        end
      end
      CMD_FLUSH: begin
        rd_d   = '0;
        wr_d   = '0;
        fill_d = '0;
      end
      default: ;
    endcase

    // Push with overwrite of the oldest entry when full
    if (push) begin
      wr_d = ptr_next(wr_q);
      if (fill_q == FILL_W'(QUEUE_DEPTH)) begin
        rd_d    = ptr_next(rd_q);
        dropped = 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end

    out_d.event_valid    = ev_valid;
    out_d.event_type     = ev_valid ? pop_ev.etype : '0;
    out_d.event_param    = ev_valid ? pop_ev.param : '0;
    out_d.knob_level     = level_d;
    out_d.queue_fill     = fill_d;
    out_d.oldest_dropped = dropped;
  end

  // Queue and knob state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q     <= '0;
      wr_q     <= '0;
      fill_q   <= '0;
      ref_q    <= '0;
      level_q  <= LEVEL_RESET;
      seeded_q <= 1'b0;
      last_q   <= '0;
    end else if (cmd_i.exec) begin
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      fill_q   <= fill_d;
      ref_q    <= ref_d;
      level_q  <= level_d;
      seeded_q <= seeded_d;
      last_q   <= last_d;
    end
  end

  // Event storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push) begin
      store_q[wr_q] <= push_ev;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.new_is_knob = (in_data_i.command == CMD_KNOB);
  assign stat_o.div_done    = div_done;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && dropped) |=> (fill_q == FILL_W'(QUEUE_DEPTH)) && out_q.oldest_dropped)
    else $error("overwrite flagged on a queue that was not full");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && ev_valid) |=> (fill_q == $past(fill_q) - 1'b1) && out_q.event_valid)
    else $error("pop did not retire exactly one entry");

endmodule

`default_nettype wire

// ===== rtl/ievq_ctrl.sv =====
// Controller state machine: accept, divider sequencing, execute and result hand-off.
// Depends on ievq_pkg.
`default_nettype none

module ievq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ievq_pkg::ctrl_stat_t stat_i,
  output ievq_pkg::ctrl_cmd_t       cmd_o
);
  import ievq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_EXEC
  } state_e;

  state_e state_q;

  // State register and transitions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= stat_i.new_is_knob ? ST_LOAD : ST_EXEC;
          end
        end
        ST_LOAD: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (stat_i.div_done) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Commands
  assign in_stall_o      = (state_q != ST_IDLE);
  assign cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.div_start = (state_q == ST_LOAD);
  assign cmd_o.exec      = (state_q == ST_EXEC) && stat_i.out_free;

endmodule

`default_nettype wire

// ===== rtl/input_event_queue_with_knob_filter.sv =====
// Top level of the input event queue with knob filter.
// Depends on ievq_pkg, ievq_ctrl and ievq_datapath.
//
// Eight-entry event queue that overwrites its oldest entry when full, fed by key,
// matrix and knob commands, and drained by pop or flush. Every accepted item returns
// exactly one result on the output channel. Key, matrix, pop, flush and unknown
// commands go from acceptance straight to the execute state, which registers their
// result once the output is free. A knob sample first passes through the load state,
// then waits while the bit-serial divider that maps the raw reading to a level
// produces its 19 quotient bits one per cycle, then executes. The next item is taken
// once the controller is back in idle after execute; a stalled output holds it in
// execute. One item is in flight at a time; a finished result waits in the output
// register while the next item is taken.
// Configuration writes are taken at any edge with cfg_we_i high and must only be
// issued while no item is in flight.
`default_nettype none

module input_event_queue_with_knob_filter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire ievq_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output ievq_pkg::out_item_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ievq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ievq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ievq_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  ievq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ievq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire
